[hw/rtl/tts_pkg.sv]
`timescale 1ns / 1ps

package tts_pkg;

   // field widths
   localparam int unsigned POS_W    = 32;
   localparam int unsigned TEX_W    = 16;
   localparam int unsigned THR_W    = 25;
   localparam int unsigned DTEX_W   = TEX_W + 1;          // uv delta
   localparam int unsigned DPOS_W   = POS_W + 1;          // position delta
   localparam int unsigned PROD_W   = DPOS_W + DTEX_W;    // one product
   localparam int unsigned NUM_W    = PROD_W + 1;         // difference of two products
   localparam int unsigned AREA_W   = 2 * DTEX_W + 1;     // signed uv area
   localparam int unsigned FRAC_SH  = 12;                 // Q.28 / Q.24 -> Q.16
   localparam int unsigned DVD_W    = NUM_W + FRAC_SH;    // dividend magnitude
   localparam int unsigned CNT_W    = 6;                  // divider step counter width

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(168);

   // term codes, shared by controller and datapath
   localparam logic [2:0] TERM_AREA = 3'd0;
   localparam logic [2:0] TERM_TX   = 3'd1;
   localparam logic [2:0] TERM_TY   = 3'd2;
   localparam logic [2:0] TERM_TZ   = 3'd3;
   localparam logic [2:0] TERM_BX   = 3'd4;
   localparam logic [2:0] TERM_BY   = 3'd5;
   localparam logic [2:0] TERM_BZ   = 3'd6;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [TEX_W-1:0] tex_u;
      logic signed [TEX_W-1:0] tex_v;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] tangent_x;
      logic signed [POS_W-1:0] tangent_y;
      logic signed [POS_W-1:0] tangent_z;
      logic signed [POS_W-1:0] bitangent_x;
      logic signed [POS_W-1:0] bitangent_y;
      logic signed [POS_W-1:0] bitangent_z;
      logic                    degenerate;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic       capture;     // corner transaction accepted
      logic [1:0] corner;
      logic [2:0] term;
      logic       mul;         // load product register
      logic       hold_first;  // keep first product
      logic       sub;         // form difference
      logic       check;       // latch area magnitude and degenerate flag
      logic       div_start;
      logic       res_store;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic degenerate;
      logic div_done;
   } status_type;

endpackage

[hw/rtl/tts_div.sv]
`timescale 1ns / 1ps

module tts_div import tts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_W-1:0]    dividend,
   input  logic [AREA_W-1:0]   divisor,
   output logic                done,
   output logic [DVD_W-1:0]    quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [AREA_W-1:0] rem_ff, rem_in;
   logic [AREA_W-1:0] dsr_ff, dsr_in;
   logic [AREA_W:0]   trial;
   logic              ge;

   // one restoring step per cycle, quotient bits shift into the dividend register
   always_comb begin
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? AREA_W'(trial - {1'b0, dsr_ff}) : trial[AREA_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

[hw/rtl/tts_datapath.sv]
`timescale 1ns / 1ps

module tts_datapath import tts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  req_type          req_data,
   input  logic             csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data,
   output rsp_type          rsp_data
);

   logic [THR_W-1:0]         thr_ff;
   logic signed [POS_W-1:0]  p0_ff [3];
   logic signed [POS_W-1:0]  p1_ff [3];
   logic signed [TEX_W-1:0]  u0_ff, v0_ff, u1_ff, v1_ff;
   logic signed [DTEX_W-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [DPOS_W-1:0] dp1_ff [3];
   logic signed [DPOS_W-1:0] dp2_ff [3];
   logic signed [POS_W-1:0]  cur_pos [3];

   logic signed [DPOS_W-1:0] op_a;
   logic signed [DTEX_W-1:0] op_b;
   logic [1:0]               axis;
   logic signed [PROD_W-1:0] prod_ff, prod1_ff;
   logic signed [NUM_W-1:0]  num_ff;

   logic signed [AREA_W-1:0] area;
   logic [AREA_W-1:0]        amag;
   logic [AREA_W-1:0]        amag_ff;
   logic                     aneg_ff;
   logic                     degen_ff;
   logic                     sat_ff;
   logic                     sign_ff;
   logic [NUM_W-1:0]         nmag;

   logic                     div_done;
   logic [DVD_W-1:0]         quot;
   logic [POS_W-1:0]         clamped;
   logic                     clamp_hit;
   logic [POS_W-1:0]         res_ff [6];
   logic [2:0]               slot;

   assign cur_pos[0] = req_data.pos_x;
   assign cur_pos[1] = req_data.pos_y;
   assign cur_pos[2] = req_data.pos_z;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // corner capture and edge deltas
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         unique case (cmd.corner)
            2'd0: begin
               for (int i = 0; i < 3; i++) p0_ff[i] <= cur_pos[i];
               u0_ff <= req_data.tex_u;
               v0_ff <= req_data.tex_v;
            end
            2'd1: begin
               for (int i = 0; i < 3; i++) p1_ff[i] <= cur_pos[i];
               u1_ff <= req_data.tex_u;
               v1_ff <= req_data.tex_v;
            end
            default: begin
               for (int i = 0; i < 3; i++) begin
                  dp1_ff[i] <= DPOS_W'(p1_ff[i]) - DPOS_W'(p0_ff[i]);
                  dp2_ff[i] <= DPOS_W'(cur_pos[i]) - DPOS_W'(p0_ff[i]);
               end
               du1_ff <= DTEX_W'(u1_ff) - DTEX_W'(u0_ff);
               dv1_ff <= DTEX_W'(v1_ff) - DTEX_W'(v0_ff);
               du2_ff <= DTEX_W'(req_data.tex_u) - DTEX_W'(u0_ff);
               dv2_ff <= DTEX_W'(req_data.tex_v) - DTEX_W'(v0_ff);
            end
         endcase
      end
   end

   // multiplier operand selection per term and product
   always_comb begin
      axis = 2'd0;
      op_a = DPOS_W'(du1_ff);
      op_b = dv2_ff;
      unique case (cmd.term)
         TERM_AREA: begin
            op_a = cmd.hold_first ? DPOS_W'(dv1_ff) : DPOS_W'(du1_ff);
            op_b = cmd.hold_first ? du2_ff : dv2_ff;
         end
         TERM_TX, TERM_TY, TERM_TZ: begin
            axis = 2'(cmd.term - TERM_TX);
            op_a = cmd.hold_first ? dp2_ff[axis] : dp1_ff[axis];
            op_b = cmd.hold_first ? dv1_ff : dv2_ff;
         end
         TERM_BX, TERM_BY, TERM_BZ: begin
            axis = 2'(cmd.term - TERM_BX);
            op_a = cmd.hold_first ? dp1_ff[axis] : dp2_ff[axis];
            op_b = cmd.hold_first ? du2_ff : du1_ff;
         end
         default: begin
            axis = 2'd0;
         end
      endcase
   end

   // shared multiplier and difference
   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= op_a * op_b;
      if (cmd.hold_first) prod1_ff <= prod_ff;
      if (cmd.sub) num_ff <= NUM_W'(prod1_ff) - NUM_W'(prod_ff);
   end

   // area magnitude and degenerate test
   assign area = num_ff[AREA_W-1:0];
   assign amag = area[AREA_W-1] ? AREA_W'(-area) : AREA_W'(area);
   assign nmag = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         amag_ff  <= amag;
         aneg_ff  <= area[AREA_W-1];
         degen_ff <= amag <= AREA_W'(thr_ff);
      end
      if (cmd.div_start) sign_ff <= num_ff[NUM_W-1] ^ aneg_ff;
   end

   tts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({nmag, FRAC_SH'(0)}),
      .divisor  (amag_ff),
      .done     (div_done),
      .quotient (quot)
   );

   // signed clamp of the quotient
   always_comb begin
      clamp_hit = 1'b0;
      if (sign_ff) begin
         if (quot > DVD_W'(64'h8000_0000)) begin
            clamp_hit = 1'b1;
            clamped   = 32'h8000_0000;
         end else begin
            clamped = POS_W'(-quot[POS_W-1:0]);
         end
      end else begin
         if (quot > DVD_W'(64'h7FFF_FFFF)) begin
            clamp_hit = 1'b1;
            clamped   = 32'h7FFF_FFFF;
         end else begin
            clamped = quot[POS_W-1:0];
         end
      end
   end

   assign slot = cmd.term - TERM_TX;

   // component results and saturate flag
   always_ff @(posedge clock) begin
      if (cmd.check) sat_ff <= 1'b0;
      if (cmd.res_store) begin
         res_ff[slot] <= clamped;
         if (clamp_hit) sat_ff <= 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data.tangent_x   <= degen_ff ? '0 : res_ff[0];
         rsp_data.tangent_y   <= degen_ff ? '0 : res_ff[1];
         rsp_data.tangent_z   <= degen_ff ? '0 : res_ff[2];
         rsp_data.bitangent_x <= degen_ff ? '0 : res_ff[3];
         rsp_data.bitangent_y <= degen_ff ? '0 : res_ff[4];
         rsp_data.bitangent_z <= degen_ff ? '0 : res_ff[5];
         rsp_data.degenerate  <= degen_ff;
         rsp_data.saturated   <= degen_ff ? 1'b0 : sat_ff;
      end
   end

   assign status.degenerate = amag <= AREA_W'(thr_ff);
   assign status.div_done   = div_done;

endmodule

[hw/rtl/tts_ctrl.sv]
`timescale 1ns / 1ps

module tts_ctrl import tts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_MUL1     = 4'd1;
   localparam logic [3:0] S_MUL2     = 4'd2;
   localparam logic [3:0] S_SUB      = 4'd3;
   localparam logic [3:0] S_CHECK    = 4'd4;
   localparam logic [3:0] S_DIV_GO   = 4'd5;
   localparam logic [3:0] S_DIV_WAIT = 4'd6;
   localparam logic [3:0] S_OUT      = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [1:0] corner_ff, corner_in;
   logic [2:0] term_ff, term_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      corner_in    = corner_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd            = '0;
      cmd.corner     = corner_ff;
      cmd.term       = term_ff;
      cmd.capture    = accept;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (corner_ff == 2'd2) begin
                  corner_in = 2'd0;
                  term_in   = TERM_AREA;
                  state_in  = S_MUL1;
               end else begin
                  corner_in = corner_ff + 1'b1;
               end
            end
         end
         S_MUL1: begin
            cmd.mul  = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul        = 1'b1;
            cmd.hold_first = 1'b1;
            state_in       = S_SUB;
         end
         S_SUB: begin
            cmd.sub  = 1'b1;
            state_in = (term_ff == TERM_AREA) ? S_CHECK : S_DIV_GO;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (status.degenerate) begin
               state_in = S_OUT;
            end else begin
               term_in  = TERM_TX;
               state_in = S_MUL1;
            end
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.res_store = 1'b1;
               if (term_ff == TERM_BZ) begin
                  state_in = S_OUT;
               end else begin
                  term_in  = term_ff + 1'b1;
                  state_in = S_MUL1;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         corner_ff    <= 2'd0;
         term_ff      <= TERM_AREA;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/triangle_tangent_solver_core.sv]
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req_      in         req_valid/req_ready    req_type, one triangle corner
// rsp_      out        rsp_valid/rsp_ready    rsp_type, one result per triangle
// csr_      in         csr_wr_en              csr_wr_data, area threshold
//
// first and second corner of a triangle: taken in one cycle each
// third corner: the area first, then per component two products on the shared
// multiplier and their difference, a divider start and a wait while its 63 quotient bits
// form, all before the next corner is taken; a degenerate triangle skips the components
// synchronous active-high reset clears the sequencer and corner count and reloads the threshold
// a waiting result does not block corners; only a finished triangle waits for it

module triangle_tangent_solver_core import tts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   tts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tts_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

endmodule

[hw/rtl/tts_checker.sv]
`timescale 1ns / 1ps

module tts_checker import tts_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsp_type          rsp_data
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // nothing to deliver right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // ready for a corner right after reset
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

   // degenerate result carries zero vectors and no clamp
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.tangent_x == 0 && rsp_data.tangent_y == 0 &&
         rsp_data.tangent_z == 0 && rsp_data.bitangent_x == 0 &&
         rsp_data.bitangent_y == 0 && rsp_data.bitangent_z == 0 &&
         !rsp_data.saturated)
      else $error("degenerate result not zero");

   // a clamp leaves at least one component at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.tangent_x == 32'h7FFF_FFFF || rsp_data.tangent_x == 32'h8000_0000 ||
         rsp_data.tangent_y == 32'h7FFF_FFFF || rsp_data.tangent_y == 32'h8000_0000 ||
         rsp_data.tangent_z == 32'h7FFF_FFFF || rsp_data.tangent_z == 32'h8000_0000 ||
         rsp_data.bitangent_x == 32'h7FFF_FFFF || rsp_data.bitangent_x == 32'h8000_0000 ||
         rsp_data.bitangent_y == 32'h7FFF_FFFF || rsp_data.bitangent_y == 32'h8000_0000 ||
         rsp_data.bitangent_z == 32'h7FFF_FFFF || rsp_data.bitangent_z == 32'h8000_0000)
      else $error("saturated flag without clamped component");

endmodule

bind triangle_tangent_solver_core tts_checker u_tts_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data)
);

[tb/tb_triangle_tangent_solver_core.sv]
`timescale 1ns / 1ps

module tb_triangle_tangent_solver_core;
   import tts_pkg::*;

   localparam int unsigned STALL_LIMIT = 6000;
   localparam int unsigned DRAIN_CYCLES = 600;
   localparam logic [THR_W-1:0] THR_TOP = {THR_W{1'b1}};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [THR_W-1:0] csr_wr_data = '0;

   // mirror of the block state
   logic [THR_W-1:0] area_limit;
   int unsigned      corner_cnt;
   longint           held_pos [6];
   longint           held_uv [4];

   rsp_type     pending_frames [$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_cycles = 0;
   int unsigned error_count = 0;
   int unsigned triangle_count = 0;
   int unsigned degenerate_count = 0;
   int unsigned saturated_count = 0;
   int unsigned quiet_cycles = 0;

   triangle_tangent_solver_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // one Q16.16 component: truncated quotient, clamped to 32 bits
   function automatic logic [31:0] scaled_quotient(input longint num,
         input longint unsigned amag, input bit aneg, inout bit sat);
      longint unsigned q;
      longint unsigned m;
      bit neg;
      m = (num < 0) ? longint'(-num) : longint'(num);
      q = (m << FRAC_SH) / amag;
      neg = (num < 0) != aneg;
      if (q == 0) return 32'd0;
      if (neg) begin
         if (q > 64'h8000_0000) begin
            sat = 1'b1;
            q = 64'h8000_0000;
         end
         return 32'(-q);
      end
      if (q > 64'h7FFF_FFFF) begin
         sat = 1'b1;
         q = 64'h7FFF_FFFF;
      end
      return 32'(q);
   endfunction

   // tangent frame of the triangle closed by corner c
   function automatic rsp_type tangent_frame(input req_type c);
      rsp_type r;
      longint p [3];
      longint du1, dv1, du2, dv2, area, n;
      longint dp1 [3];
      longint dp2 [3];
      longint unsigned amag;
      logic [31:0] comp [6];
      bit aneg;
      bit sat;
      p[0] = c.pos_x;
      p[1] = c.pos_y;
      p[2] = c.pos_z;
      du1 = held_uv[2] - held_uv[0];
      dv1 = held_uv[3] - held_uv[1];
      du2 = longint'(c.tex_u) - held_uv[0];
      dv2 = longint'(c.tex_v) - held_uv[1];
      area = du1 * dv2 - dv1 * du2;
      amag = (area < 0) ? longint'(-area) : longint'(area);
      aneg = area < 0;
      sat = 1'b0;
      r = '0;
      if (amag <= longint'(area_limit)) begin
         r.degenerate = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         dp1[i] = held_pos[3 + i] - held_pos[i];
         dp2[i] = p[i] - held_pos[i];
      end
      for (int i = 0; i < 3; i++) begin
         n = dp1[i] * dv2 - dp2[i] * dv1;
         comp[i] = scaled_quotient(n, amag, aneg, sat);
         n = dp2[i] * du1 - dp1[i] * du2;
         comp[3 + i] = scaled_quotient(n, amag, aneg, sat);
      end
      r.tangent_x = comp[0];
      r.tangent_y = comp[1];
      r.tangent_z = comp[2];
      r.bitangent_x = comp[3];
      r.bitangent_y = comp[4];
      r.bitangent_z = comp[5];
      r.saturated = sat;
      return r;
   endfunction

   // update mirror state for one accepted corner
   task automatic take_corner(input req_type c);
      rsp_type r;
      if (corner_cnt < 2) begin
         held_pos[corner_cnt * 3] = c.pos_x;
         held_pos[corner_cnt * 3 + 1] = c.pos_y;
         held_pos[corner_cnt * 3 + 2] = c.pos_z;
         held_uv[corner_cnt * 2] = c.tex_u;
         held_uv[corner_cnt * 2 + 1] = c.tex_v;
         corner_cnt++;
      end else begin
         corner_cnt = 0;
         r = tangent_frame(c);
         pending_frames.push_back(r);
         triangle_count++;
         if (r.degenerate) degenerate_count++;
         if (r.saturated) saturated_count++;
      end
   endtask

   // drive one corner transaction and wait for acceptance
   task automatic send_corner(input req_type c);
      @(negedge clock);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= c;
      do @(posedge clock); while (!req_ready);
      take_corner(c);
   endtask

   task automatic send_triangle(input req_type a, input req_type b, input req_type c);
      send_corner(a);
      send_corner(b);
      send_corner(c);
   endtask

   function automatic req_type corner(input int px, input int py, input int pz,
         input shortint u, input shortint v);
      req_type c;
      c.pos_x = px;
      c.pos_y = py;
      c.pos_z = pz;
      c.tex_u = u;
      c.tex_v = v;
      return c;
   endfunction

   // mostly modest positions, sometimes full range
   function automatic req_type random_corner();
      req_type c;
      c = req_type'({$urandom, $urandom, $urandom, 16'($urandom), 16'($urandom)});
      if ($urandom_range(3) != 0) begin
         c.pos_x = $signed(c.pos_x) >>> $urandom_range(8, 14);
         c.pos_y = $signed(c.pos_y) >>> $urandom_range(8, 14);
         c.pos_z = $signed(c.pos_z) >>> $urandom_range(8, 14);
      end
      if ($urandom_range(3) == 0) begin
         c.tex_u = $signed(c.tex_u) >>> $urandom_range(4, 14);
         c.tex_v = $signed(c.tex_v) >>> $urandom_range(4, 14);
      end
      return c;
   endfunction

   // stop offering corners, wait until the block is quiet, then write the threshold
   task automatic write_threshold(input logic [THR_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      area_limit = value;
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
         input logic [31:0] want);
      $display("mismatch %s: got %h expected %h", field, got, want);
      error_count++;
   endtask

   // receiver: random stalls plus a counted long hold-off
   always @(negedge clock) begin
      if (hold_cycles != 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frames.size() == 0) begin
            $display("unexpected result transaction %h", rsp_data);
            error_count++;
         end else begin
            w = pending_frames.pop_front();
            if (rsp_data.tangent_x !== w.tangent_x)
               report_mismatch("tangent_x", rsp_data.tangent_x, w.tangent_x);
            if (rsp_data.tangent_y !== w.tangent_y)
               report_mismatch("tangent_y", rsp_data.tangent_y, w.tangent_y);
            if (rsp_data.tangent_z !== w.tangent_z)
               report_mismatch("tangent_z", rsp_data.tangent_z, w.tangent_z);
            if (rsp_data.bitangent_x !== w.bitangent_x)
               report_mismatch("bitangent_x", rsp_data.bitangent_x, w.bitangent_x);
            if (rsp_data.bitangent_y !== w.bitangent_y)
               report_mismatch("bitangent_y", rsp_data.bitangent_y, w.bitangent_y);
            if (rsp_data.bitangent_z !== w.bitangent_z)
               report_mismatch("bitangent_z", rsp_data.bitangent_z, w.bitangent_z);
            if (rsp_data.degenerate !== w.degenerate)
               report_mismatch("degenerate", 32'(rsp_data.degenerate), 32'(w.degenerate));
            if (rsp_data.saturated !== w.saturated)
               report_mismatch("saturated", 32'(rsp_data.saturated), 32'(w.saturated));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // plain, degenerate, extreme and saturating triangles at reset threshold
   task automatic test_directed_shapes();
      send_triangle(corner(0, 0, 0, 0, 0), corner(32'h1_0000, 0, 0, 16'h1000, 0),
         corner(0, 32'h1_0000, 0, 0, 16'h1000));
      // zero uv area
      send_triangle(corner(5, 6, 7, 100, 100), corner(-5, 9, 1, 100, 100),
         corner(3, -3, 8, 100, 100));
      send_triangle(corner(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF),
         corner(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000),
         corner(32'hFFFF_FFFF, 0, 1, 16'h8000, 16'h8000));
      send_triangle(corner(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0),
         corner(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4, 0),
         corner(0, 0, 0, 0, 50));
   endtask

   // zero threshold: unit area passes, zero area is degenerate
   task automatic test_zero_threshold();
      write_threshold('0);
      send_triangle(corner(0, 0, 0, 0, 0), corner(32'h10_0000, -32'h10_0000, 7, 1, 0),
         corner(-32'h20_0000, 32'h30_0000, 9, 0, 1));
      send_triangle(corner(1, 2, 3, 7, 7), corner(4, 5, 6, 7, 7), corner(7, 8, 9, 7, 7));
   endtask

   // top thresholds, full 25 bits used as written
   task automatic test_high_threshold();
      write_threshold(THR_W'(16777216));
      send_triangle(corner(0, 0, 0, 0, 0), corner(32'h1_0000, 0, 0, 16'h1000, 0),
         corner(0, 32'h1_0000, 0, 0, 16'h1000));
      write_threshold(THR_TOP);
      send_triangle(corner(0, 0, 0, 0, 0), corner(32'h1_0000, 0, 0, 16'h2000, 0),
         corner(0, 32'h1_0000, 0, 0, 16'h1000));
      send_triangle(corner(0, 0, 0, 0, 0), corner(32'h1_0000, 0, 0, 16'h7FFF, 0),
         corner(0, 32'h1_0000, 0, 0, 16'h7FFF));
   endtask

   // long receiver hold-off while corners keep coming
   task automatic test_backpressure();
      write_threshold(THR_RESET);
      send_idle_pct = 0;
      hold_cycles = 2000;
      repeat (12) send_triangle(random_corner(), random_corner(), random_corner());
   endtask

   // random triangles under one idling pattern
   task automatic test_random_phase(input int unsigned tris, input int unsigned s_pct,
         input int unsigned r_pct);
      req_type a;
      write_threshold(($urandom_range(3) == 0) ? THR_W'($urandom) :
         THR_W'($urandom_range(0, 4096)));
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (tris) begin
         a = random_corner();
         case ($urandom_range(9))
            0: send_triangle(a, random_corner(), corner($urandom, $urandom, $urandom,
                  a.tex_u, a.tex_v));
            1: send_triangle(a, corner($urandom, $urandom, $urandom,
                  a.tex_u + 16'sd1, a.tex_v), random_corner());
            default: send_triangle(a, random_corner(), random_corner());
         endcase
      end
   endtask

   initial begin
      area_limit = THR_RESET;
      corner_cnt = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_shapes();
      test_zero_threshold();
      test_high_threshold();
      test_backpressure();
      test_random_phase(175, 37, 50);
      test_random_phase(175, 50, 37);
      test_random_phase(170, 0, 0);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d triangles: %0d degenerate, %0d saturated", triangle_count,
         degenerate_count, saturated_count);
      $display("thresholds zero, reset, top and random; idle mixes and a long hold-off");
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
